[rtl/core/lcs_pkg.sv]
// Shared constants and types for the longest common substring block.
// No dependencies.
package lcs_pkg;
  localparam int MAX_LEN = 64;
  localparam int IDX_W   = $clog2(MAX_LEN);
  localparam int LEN_W   = $clog2(MAX_LEN + 1);

  typedef enum logic [2:0] {
    ST_LOAD,
    ST_FILL_RD,
    ST_FILL_EX,
    ST_CMP_RD,
    ST_CMP_EX,
    ST_OUT_RD,
    ST_OUT_LD,
    ST_OUT_WAIT
  } lcs_state_t;
endpackage

[rtl/core/lcs_if.sv]
// Valid/ready channel interfaces for the input and result items.
// Depends on nothing.
interface lcs_in_if;
  logic       valid;
  logic       ready;
  logic       string_select;
  logic       has_char;
  logic [7:0] char_value;
  logic       last_char;
  modport source (output valid, string_select, has_char, char_value, last_char,
                  input ready);
  modport sink   (input valid, string_select, has_char, char_value, last_char,
                  output ready);
endinterface

interface lcs_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_char;
  logic       found;
  logic [6:0] match_length;
  logic       last_out;
  logic       overflow;
  modport source (output valid, out_char, found, match_length, last_out, overflow,
                  input ready);
  modport sink   (input valid, out_char, found, match_length, last_out, overflow,
                  output ready);
endinterface

[rtl/core/lcs_ram.sv]
// Generic synchronous RAM: one write port, two registered read ports.
// No dependencies.
module lcs_ram #(
  parameter int W = 8,
  parameter int D = 64
) (
  input  logic                 clk,
  input  logic                 we,
  input  logic [$clog2(D)-1:0] waddr,
  input  logic [W-1:0]         wdata,
  input  logic [$clog2(D)-1:0] raddr_a,
  output logic [W-1:0]         rdata_a,
  input  logic [$clog2(D)-1:0] raddr_b,
  output logic [W-1:0]         rdata_b
);
  logic [W-1:0] mem [D];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_a <= mem[raddr_a];
    rdata_b <= mem[raddr_b];
  end
endmodule

[rtl/core/longest_common_substring_top.sv]
// Longest common substring block: loads two strings, then scans the run table.
// Depends on lcs_pkg, lcs_in_if/lcs_out_if and lcs_ram.
//
// Load both strings one byte per item. When the second string closes with both
// strings non-empty, the block walks the run table one cell at a time (RAM read,
// then compare and write back); an equal-length tie adds a byte-by-byte compare
// on the first-string RAM. Results then leave one byte at a time (RAM read, load,
// then wait for the sink). No input item is taken from the close of the second
// string until the last result of its answer is taken.
module longest_common_substring_top (
  input  logic clk,
  input  logic rst,
  lcs_in_if.sink    in_ch,
  lcs_out_if.source out_ch
);
  import lcs_pkg::*;

  lcs_state_t state, state_next;

  logic [LEN_W-1:0] first_len, second_len, best_len, i, j, cmp_left;
  logic [IDX_W-1:0] best_end, cand_end, cmp_a, cmp_b, optr;
  logic             first_closed, truncated, fill_done;

  logic [7:0]       o_char;
  logic             o_valid, o_found, o_last, o_ovf;
  logic [LEN_W-1:0] o_len;

  // memory ports
  logic             ft_we, st_we, rr_we;
  logic [IDX_W-1:0] ft_waddr, st_waddr, rr_waddr, ft_ra, ft_rb, st_ra, rr_ra;
  logic [7:0]       ft_da, ft_db, st_da;
  logic [LEN_W-1:0] rr_wdata, rr_da;

  logic             acc;
  logic [LEN_W-1:0] fbase, sl_new, prev, v, j_m1;

  lcs_ram #(.W(8), .D(MAX_LEN)) u_first (
    .clk, .we(ft_we), .waddr(ft_waddr), .wdata(in_ch.char_value),
    .raddr_a(ft_ra), .rdata_a(ft_da), .raddr_b(ft_rb), .rdata_b(ft_db));
  lcs_ram #(.W(8), .D(MAX_LEN)) u_second (
    .clk, .we(st_we), .waddr(st_waddr), .wdata(in_ch.char_value),
    .raddr_a(st_ra), .rdata_a(st_da), .raddr_b(st_ra), .rdata_b());
  lcs_ram #(.W(LEN_W), .D(MAX_LEN)) u_row (
    .clk, .we(rr_we), .waddr(rr_waddr), .wdata(rr_wdata),
    .raddr_a(rr_ra), .rdata_a(rr_da), .raddr_b(rr_ra), .rdata_b());

  assign in_ch.ready         = (state == ST_LOAD);
  assign acc                 = in_ch.valid && in_ch.ready;
  assign out_ch.valid        = o_valid;
  assign out_ch.out_char     = o_char;
  assign out_ch.found        = o_found;
  assign out_ch.match_length = o_len;
  assign out_ch.last_out     = o_last;
  assign out_ch.overflow     = o_ovf;

  always_comb begin
    fbase = first_closed ? '0 : first_len;
    sl_new = second_len;
    if (in_ch.has_char && second_len < LEN_W'(MAX_LEN)) begin
      sl_new = second_len + 1'b1;
    end
    ft_we    = acc && !in_ch.string_select && in_ch.has_char && fbase < LEN_W'(MAX_LEN);
    ft_waddr = fbase[IDX_W-1:0];
    st_we    = acc && in_ch.string_select && in_ch.has_char && second_len < LEN_W'(MAX_LEN);
    st_waddr = second_len[IDX_W-1:0];
    j_m1     = j - 1'b1;
    // first row and leftmost column see a zero run
    prev     = (i == LEN_W'(1) || j == LEN_W'(1)) ? '0 : rr_da;
    v        = prev + 1'b1;
    ft_ra    = j_m1[IDX_W-1:0];
    ft_rb    = cmp_b;
    st_ra    = j_m1[IDX_W-1:0];
    rr_ra    = IDX_W'(j - LEN_W'(2));
    unique case (state)
      ST_FILL_RD: begin
        ft_ra = IDX_W'(i - 1'b1);
      end
      ST_CMP_RD: begin
        ft_ra = cmp_a;
      end
      ST_OUT_RD: begin
        ft_ra = optr;
      end
      default: begin
        ft_ra = IDX_W'(i - 1'b1);
      end
    endcase
    rr_we    = (state == ST_FILL_EX);
    rr_waddr = j_m1[IDX_W-1:0];
    rr_wdata = (ft_da == st_da) ? v : '0;
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_LOAD: begin
        if (acc && in_ch.string_select && in_ch.last_char) begin
          if (first_len != '0 && sl_new != '0) begin
            state_next = ST_FILL_RD;
          end else begin
            state_next = ST_OUT_WAIT;
          end
        end
      end
      ST_FILL_RD: state_next = ST_FILL_EX;
      ST_FILL_EX: begin
        if (ft_da == st_da && v == best_len && v <= best_len) begin
          state_next = ST_CMP_RD;
        end else if (j == LEN_W'(1) && i == first_len) begin
          state_next = ST_OUT_RD;
        end else begin
          state_next = ST_FILL_RD;
        end
        if (ft_da == st_da && v > best_len) begin
          state_next = (j == LEN_W'(1) && i == first_len) ? ST_OUT_RD : ST_FILL_RD;
        end
      end
      ST_CMP_RD: state_next = ST_CMP_EX;
      ST_CMP_EX: begin
        if (ft_da != ft_db || cmp_left == LEN_W'(1)) begin
          state_next = fill_done ? ST_OUT_RD : ST_FILL_RD;
        end else begin
          state_next = ST_CMP_RD;
        end
      end
      ST_OUT_RD: state_next = (best_len == '0) ? ST_OUT_WAIT : ST_OUT_LD;
      ST_OUT_LD: state_next = ST_OUT_WAIT;
      ST_OUT_WAIT: begin
        if (out_ch.ready) begin
          state_next = o_last ? ST_LOAD : ST_OUT_RD;
        end
      end
      default: state_next = ST_LOAD;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_LOAD;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      first_len    <= '0;
      second_len   <= '0;
      first_closed <= 1'b0;
      truncated    <= 1'b0;
      best_len     <= '0;
      best_end     <= '0;
      o_valid      <= 1'b0;
    end else begin
      unique case (state)
        ST_LOAD: begin
          if (acc && !in_ch.string_select) begin
            first_len    <= fbase;
            first_closed <= in_ch.last_char;
            if (in_ch.has_char) begin
              if (fbase < LEN_W'(MAX_LEN)) begin
                first_len <= fbase + 1'b1;
              end else begin
                truncated <= 1'b1;
              end
            end
          end else if (acc) begin
            second_len <= sl_new;
            if (in_ch.has_char && second_len == LEN_W'(MAX_LEN)) begin
              truncated <= 1'b1;
            end
            if (in_ch.last_char) begin
              best_len <= '0;
              best_end <= '0;
              i        <= LEN_W'(1);
              j        <= sl_new;
              // empty string: answer at once
              o_valid  <= !(first_len != '0 && sl_new != '0);
              o_char   <= '0;
              o_found  <= 1'b0;
              o_len    <= '0;
              o_last   <= 1'b1;
              o_ovf    <= truncated ||
                          (in_ch.has_char && second_len == LEN_W'(MAX_LEN));
            end
          end
        end
        ST_FILL_EX: begin
          fill_done <= (j == LEN_W'(1) && i == first_len);
          if (j == LEN_W'(1)) begin
            i <= i + 1'b1;
            j <= second_len;
          end else begin
            j <= j_m1;
          end
          cand_end <= IDX_W'(i - 1'b1);
          cmp_left <= v;
          cmp_a    <= IDX_W'(i - v);
          cmp_b    <= IDX_W'(LEN_W'(best_end) + 1'b1 - v);
          if (ft_da == st_da && v > best_len) begin
            best_len <= v;
            best_end <= IDX_W'(i - 1'b1);
          end
        end
        ST_CMP_EX: begin
          if (ft_da != ft_db) begin
            if (ft_da < ft_db) begin
              best_end <= cand_end;
            end
          end else begin
            cmp_left <= cmp_left - 1'b1;
            cmp_a    <= cmp_a + 1'b1;
            cmp_b    <= cmp_b + 1'b1;
          end
          optr <= IDX_W'(LEN_W'((ft_da < ft_db) ? cand_end : best_end) + 1'b1 - best_len);
        end
        ST_OUT_RD: begin
          if (best_len == '0) begin
            o_valid <= 1'b1;
            o_char  <= '0;
            o_found <= 1'b0;
            o_len   <= '0;
            o_last  <= 1'b1;
            o_ovf   <= truncated;
          end
        end
        ST_OUT_LD: begin
          o_valid <= 1'b1;
          o_char  <= ft_da;
          o_found <= 1'b1;
          o_len   <= best_len;
          o_last  <= (optr == best_end);
          o_ovf   <= truncated;
        end
        ST_OUT_WAIT: begin
          if (out_ch.ready) begin
            o_valid <= 1'b0;
            optr    <= optr + 1'b1;
            if (o_last) begin
              first_len    <= '0;
              second_len   <= '0;
              truncated    <= 1'b0;
              first_closed <= 1'b0;
            end
          end
        end
        default: begin
        end
      endcase
      if (state == ST_FILL_EX) begin
        optr <= IDX_W'(LEN_W'((ft_da == st_da && v > best_len) ? IDX_W'(i - 1'b1)
                              : best_end) + 1'b1
                       - ((ft_da == st_da && v > best_len) ? v : best_len));
      end
    end
  end
endmodule

[verif/longest_common_substring_top_test.sv]
// Testbench for longest_common_substring_top: directed table, then random string pairs.
// Depends on lcs_pkg, lcs_in_if/lcs_out_if and the block itself.
`timescale 1ns / 100ps

module longest_common_substring_top_test;
  import lcs_pkg::*;

  typedef struct packed {
    logic [7:0] ch;
    logic       found;
    logic [6:0] len;
    logic       last;
    logic       ovf;
  } answer_byte_t;

  typedef enum logic [1:0] {ROW_PREDICT, ROW_NO_MATCH} row_kind_t;

  typedef struct packed {
    logic       sel;
    logic       has;
    logic [7:0] ch;
    logic       last;
    row_kind_t  kind;
  } stim_row_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  lcs_in_if  in_ch ();
  lcs_out_if out_ch ();

  longest_common_substring_top dut (
    .clk    (clk),
    .rst    (rst),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  always #2 clk = ~clk;

  // predictor state
  logic [7:0] text_a [MAX_LEN];
  logic [7:0] text_b [MAX_LEN];
  int         len_a, len_b;
  bit         cut, a_closed;
  answer_byte_t answer_q [$];

  int errors, results_seen, items_sent, answers, ovf_answers, burst_left, hold_cycles;

  // lexicographic check of two runs ending at a and b in the first string
  function automatic bit run_smaller(int a, int b, int n);
    int k;
    for (k = 0; k < n; k++) begin
      if (text_a[a + 1 - n + k] != text_a[b + 1 - n + k])
        return text_a[a + 1 - n + k] < text_a[b + 1 - n + k];
    end
    return 1'b0;
  endfunction

  task automatic predict_item(input logic sel, input logic has, input logic [7:0] ch,
                              input logic last);
    int row [MAX_LEN + 1];
    int best, best_end, i, j, v, k;
    answer_byte_t r;
    if (!sel) begin
      if (a_closed) begin
        len_a = 0;
        a_closed = 0;
      end
      if (has) begin
        if (len_a < MAX_LEN) text_a[len_a++] = ch;
        else cut = 1;
      end
      if (last) a_closed = 1;
      return;
    end
    if (has) begin
      if (len_b < MAX_LEN) text_b[len_b++] = ch;
      else cut = 1;
    end
    if (!last) return;
    best = 0;
    best_end = 0;
    foreach (row[x]) row[x] = 0;
    if (len_a != 0 && len_b != 0) begin
      for (i = 1; i <= len_a; i++) begin
        for (j = len_b; j >= 1; j--) begin
          if (text_a[i - 1] == text_b[j - 1]) begin
            v = row[j - 1] + 1;
            row[j] = v;
            if (v > best) begin
              best = v;
              best_end = i - 1;
            end else if (v == best && run_smaller(i - 1, best_end, v)) begin
              best_end = i - 1;
            end
          end else begin
            row[j] = 0;
          end
        end
      end
    end
    answers++;
    if (cut) ovf_answers++;
    if (best == 0) begin
      r = '{ch: 8'h00, found: 1'b0, len: 7'd0, last: 1'b1, ovf: cut};
      answer_q = {answer_q, r};
    end else begin
      for (k = 0; k < best; k++) begin
        r = '{ch: text_a[best_end + 1 - best + k], found: 1'b1, len: 7'(best),
              last: (k == best - 1), ovf: cut};
        answer_q = {answer_q, r};
      end
    end
    len_a = 0;
    len_b = 0;
    cut = 0;
    a_closed = 0;
  endtask

  task automatic send_item(input logic sel, input logic has, input logic [7:0] ch,
                           input logic last);
    @(negedge clk);
    if (burst_left == 0) begin
      in_ch.valid = 1'b0;
      repeat ($urandom_range(1, 6)) @(negedge clk);
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 60) : $urandom_range(1, 8);
    end
    in_ch.valid = 1'b1;
    in_ch.string_select = sel;
    in_ch.has_char = has;
    in_ch.char_value = ch;
    in_ch.last_char = last;
    burst_left--;
    do @(posedge clk); while (!in_ch.ready);
    items_sent++;
    predict_item(sel, has, ch, last);
  endtask

  task automatic send_string(input logic sel, input int n, input int base, input int spread);
    int k;
    if (n == 0) begin
      send_item(sel, 1'b0, 8'($urandom_range(0, 255)), 1'b1);
      return;
    end
    for (k = 0; k < n; k++)
      send_item(sel, 1'b1, 8'((base + $urandom_range(0, spread)) & 8'hFF), k == n - 1);
  endtask

  // receiver: stall pattern (always ready, random, or sparse) re-picked at random, with an optional long hold-off
  initial begin
    int mode, tick;
    out_ch.ready = 1'b0;
    tick = 0;
    mode = 0;
    forever begin
      @(negedge clk);
      if (tick % 64 == 0) mode = $urandom_range(0, 2);
      tick++;
      if (hold_cycles > 0) begin
        hold_cycles--;
        out_ch.ready = 1'b0;
      end else if (mode == 0) out_ch.ready = 1'b1;
      else if (mode == 1) out_ch.ready = 1'($urandom_range(0, 1));
      else out_ch.ready = (tick % 4 == 0);
    end
  end

  always @(posedge clk) begin
    answer_byte_t want, got;
    if (!rst && out_ch.valid && out_ch.ready) begin
      got = '{ch: out_ch.out_char, found: out_ch.found, len: out_ch.match_length,
              last: out_ch.last_out, ovf: out_ch.overflow};
      results_seen++;
      if (answer_q.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected result %p", got);
      end else begin
        want = answer_q.pop_front();
        if (got != want) begin
          errors++;
          if (errors <= 10) $display("mismatch: expected %p, got %p", want, got);
        end
      end
    end
  end

  initial begin
    #20_000_000;
    $display("timeout with %0d results outstanding", answer_q.size());
    $display("Some tests failed");
    $finish;
  end

  stim_row_t directed [21] = '{
    '{1'b1, 1'b0, 8'h00, 1'b1, ROW_NO_MATCH},  // both strings empty
    '{1'b0, 1'b1, 8'h00, 1'b1, ROW_PREDICT},
    '{1'b1, 1'b1, 8'hFF, 1'b1, ROW_NO_MATCH},  // no common byte
    '{1'b0, 1'b1, 8'hFF, 1'b0, ROW_PREDICT},
    '{1'b0, 1'b1, 8'h00, 1'b1, ROW_PREDICT},
    '{1'b1, 1'b1, 8'h00, 1'b0, ROW_PREDICT},
    '{1'b1, 1'b1, 8'hFF, 1'b1, ROW_PREDICT},   // tie, smaller byte wins
    '{1'b0, 1'b0, 8'h00, 1'b1, ROW_PREDICT},
    '{1'b1, 1'b1, 8'h41, 1'b1, ROW_NO_MATCH},  // empty first string
    '{1'b0, 1'b1, 8'h41, 1'b1, ROW_PREDICT},
    '{1'b1, 1'b0, 8'h00, 1'b1, ROW_NO_MATCH},  // empty second string
    '{1'b1, 1'b1, 8'h5A, 1'b0, ROW_PREDICT},   // second string before first closes
    '{1'b0, 1'b1, 8'h5A, 1'b0, ROW_PREDICT},
    '{1'b0, 1'b1, 8'hA5, 1'b0, ROW_PREDICT},
    '{1'b1, 1'b1, 8'hA5, 1'b1, ROW_PREDICT},
    '{1'b0, 1'b1, 8'h01, 1'b1, ROW_PREDICT},
    '{1'b0, 1'b1, 8'h02, 1'b0, ROW_PREDICT},   // reopens the first string
    '{1'b0, 1'b1, 8'h03, 1'b1, ROW_PREDICT},
    '{1'b1, 1'b1, 8'h01, 1'b0, ROW_PREDICT},
    '{1'b1, 1'b1, 8'h02, 1'b0, ROW_PREDICT},
    '{1'b1, 1'b1, 8'h03, 1'b1, ROW_PREDICT}
  };

  initial begin
    int n, pair, base, spread, k;
    logic [7:0] same [66];
    answer_byte_t typed;
    in_ch.valid = 1'b0;
    in_ch.string_select = 1'b0;
    in_ch.has_char = 1'b0;
    in_ch.char_value = 8'h00;
    in_ch.last_char = 1'b0;
    len_a = 0; len_b = 0; cut = 0; a_closed = 0;
    errors = 0; results_seen = 0; items_sent = 0; answers = 0; ovf_answers = 0;
    burst_left = 0; hold_cycles = 0;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    foreach (directed[r]) begin
      send_item(directed[r].sel, directed[r].has, directed[r].ch, directed[r].last);
      if (directed[r].kind == ROW_NO_MATCH) begin
        void'(answer_q.pop_back());
        typed = '{ch: 8'h00, found: 1'b0, len: 7'd0, last: 1'b1, ovf: 1'b0};
        answer_q = {answer_q, typed};
      end
    end

    // sender pauses until the block has drained
    @(negedge clk);
    in_ch.valid = 1'b0;
    while (answer_q.size() != 0) @(posedge clk);

    pair = 0;
    while (items_sent < 260) begin
      pair++;
      if (pair == 2) begin
        // identical strings past the limit: full-length match with overflow
        for (k = 0; k < 66; k++) same[k] = 8'($urandom_range(0, 255));
        for (k = 0; k < 66; k++) send_item(1'b0, 1'b1, same[k], k == 65);
        for (k = 0; k < 66; k++) send_item(1'b1, 1'b1, same[k], k == 65);
        continue;
      end
      if (pair == 6) hold_cycles = 400;
      if ($urandom_range(0, 11) == 0) begin
        // noise: fully random item fields
        send_item(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                  8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
        continue;
      end
      base = $urandom_range(0, 255);
      spread = $urandom_range(0, 3);
      if ($urandom_range(0, 9) == 0)
        send_string(1'b1, $urandom_range(1, 3), base, spread);  // early second-string bytes
      n = $urandom_range(0, 8);
      if ($urandom_range(0, 14) == 0) n = $urandom_range(60, 68);
      send_string(1'b0, n, base, spread);
      send_string(1'b1, $urandom_range(0, 8), base, spread);
    end

    @(negedge clk);
    in_ch.valid = 1'b0;
    while (answer_q.size() != 0) @(posedge clk);
    repeat (200) @(posedge clk);

    $display("%0d items sent, %0d answers (%0d with overflow), %0d result bytes checked",
             items_sent, answers, ovf_answers, results_seen);
    if (errors == 0 && answer_q.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("%0d mismatches", errors);
      $display("Some tests failed");
    end
    $finish;
  end
endmodule

[filelist.f]
rtl/core/lcs_pkg.sv
rtl/core/lcs_if.sv
rtl/core/lcs_ram.sv
rtl/core/longest_common_substring_top.sv
verif/longest_common_substring_top_test.sv
